/* rtl/dalf_pkg.sv */
package dalf_pkg;

    localparam int VALUE_W        = 32;
    localparam int CMD_W          = 8;
    localparam int BYTE_W         = 8;
    localparam int CONV_DIGITS    = 10;
    localparam int BCD_W          = 4 * CONV_DIGITS;
    localparam int BITS_PER_STAGE = 8;
    localparam int N_STAGES       = VALUE_W / BITS_PER_STAGE;
    localparam int DIGITS_DEFAULT = 10;
    localparam int DIGITS_MAX     = 20;

    localparam logic [CMD_W-1:0]  CMD_THRESHOLD = 8'h80;
    localparam logic [BYTE_W-1:0] ASCII_ZERO    = 8'd48;
    localparam logic [BYTE_W-1:0] ASCII_NINE    = 8'd57;

    // Input word: cursor command and the value to print.
    typedef struct packed {
        logic [CMD_W-1:0]   cursor_cmd;
        logic [VALUE_W-1:0] value;
    } t_in_word;

    // Output word: one display byte.
    typedef struct packed {
        logic              is_command;
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } t_out_word;

    // Word moving through the conversion stages.
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] bits;
        logic [BCD_W-1:0]   bcd;
    } t_conv;

    // One shift-and-add-3 step: correct every digit of five or more, then shift in one bit.
    function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                      input logic in_bit);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int d = 0; d < CONV_DIGITS; d++) begin
            if (adj[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], in_bit};
    endfunction

endpackage

/* rtl/dalf_dabble_stage.sv */
module dalf_dabble_stage
    import dalf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_conv i_data,
    output logic  o_valid,
    input  logic  i_stall,
    output t_conv o_data
);

    logic  r_valid;
    t_conv r_data;
    t_conv n_data;
    logic  advance;

    // The stage moves when it is empty or its word is being taken.
    assign advance = !r_valid || !i_stall;
    assign o_stall = !advance;

    // Shift the next group of value bits into the decimal digits, MSB first.
    always_comb begin
        n_data = i_data;
        for (int b = 0; b < BITS_PER_STAGE; b++) begin
            n_data.bcd  = dabble_step(n_data.bcd, n_data.bits[VALUE_W-1]);
            n_data.bits = {n_data.bits[VALUE_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_data <= n_data;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* rtl/dalf_scan.sv */
module dalf_scan
    import dalf_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEFAULT,
    localparam int IW    = (DIGITS > 1) ? $clog2(DIGITS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_conv                 i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [CMD_W-1:0]      o_cmd,
    output logic [DIGITS-1:0][3:0] o_digits,
    output logic [IW-1:0]         o_top
);

    localparam int EXT_W = ((DIGITS > CONV_DIGITS) ? DIGITS : CONV_DIGITS) * 4;

    logic                   r_valid;
    logic [CMD_W-1:0]       r_cmd;
    logic [DIGITS-1:0][3:0] r_digits;
    logic [IW-1:0]          r_top;
    logic [EXT_W-1:0]       bcd_ext;
    logic [DIGITS-1:0][3:0] n_digits;
    logic [IW-1:0]          n_top;
    logic                   advance;

    assign advance = !r_valid || !i_stall;
    assign o_stall = !advance;

    // Keep the low DIGITS decimal places; places above the converter read as zero.
    assign bcd_ext  = EXT_W'(i_data.bcd);
    assign n_digits = bcd_ext[DIGITS*4-1:0];

    // Find the most significant nonzero place; zero prints as a single digit.
    always_comb begin
        n_top = '0;
        for (int k = 0; k < DIGITS; k++) begin
            if (n_digits[k] != 4'd0) begin
                n_top = IW'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_cmd    <= i_data.cmd;
                r_digits <= n_digits;
                r_top    <= n_top;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_cmd    = r_cmd;
    assign o_digits = r_digits;
    assign o_top    = r_top;

endmodule

/* rtl/dalf_serializer.sv */
module dalf_serializer
    import dalf_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEFAULT,
    localparam int IW    = (DIGITS > 1) ? $clog2(DIGITS) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [CMD_W-1:0]       i_cmd,
    input  logic [DIGITS-1:0][3:0] i_digits,
    input  logic [IW-1:0]          i_top,
    output logic                   o_valid,
    input  logic                   i_stall,
    output t_out_word              o_word
);

    logic                   r_valid;
    t_out_word              r_word;
    logic                   r_more;
    logic [IW-1:0]          r_idx;
    logic [DIGITS-1:0][3:0] r_digits;
    logic                   advance;
    logic [BYTE_W-1:0]      held_char;
    logic [BYTE_W-1:0]      load_char;

    // The output register moves when empty or taken; a new run loads only after the last byte.
    assign advance = !r_valid || !i_stall;
    assign o_stall = !(advance && !r_more);

    assign held_char = ASCII_ZERO + {4'd0, r_digits[r_idx]};
    assign load_char = ASCII_ZERO + {4'd0, i_digits[i_top]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_more  <= 1'b0;
        end else if (advance) begin
            if (r_more) begin
                // Next digit of the run in progress.
                r_valid           <= 1'b1;
                r_word.is_command <= 1'b0;
                r_word.out_byte   <= held_char;
                r_word.last       <= (r_idx == '0);
                r_more            <= (r_idx != '0);
                r_idx             <= r_idx - IW'(1);
            end else if (i_valid) begin
                r_valid  <= 1'b1;
                r_digits <= i_digits;
                if (i_cmd >= CMD_THRESHOLD) begin
                    // The command goes first; all digits follow.
                    r_word.is_command <= 1'b1;
                    r_word.out_byte   <= i_cmd;
                    r_word.last       <= 1'b0;
                    r_more            <= 1'b1;
                    r_idx             <= i_top;
                end else begin
                    r_word.is_command <= 1'b0;
                    r_word.out_byte   <= load_char;
                    r_word.last       <= (i_top == '0);
                    r_more            <= (i_top != '0);
                    r_idx             <= i_top - IW'(1);
                end
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

/* rtl/decimal_ascii_lcd_formatter_core.sv */
// Decimal formatter for a character display. Each input word carries a cursor command and a
// 32-bit unsigned value; the block sends the command first (marked as a command) when it is
// 0x80 or higher, then the ASCII decimal digits of the value, most significant first, with
// leading zeros dropped, so zero prints as one '0'. Only the low DIGITS decimal places are
// printed. The last byte of each run carries the last flag. Conversion runs in four
// shift-and-add-3 stages of eight bits each, then a digit scan stage, then an output register.
// The pipeline takes a new word every cycle until the output serializer backs it up: the
// serializer sends one byte per cycle while the output is not stalled, and loads a new word
// only after the last byte of its run; a run has from 1 up to DIGITS + 1 bytes (eleven at the
// default). The block keeps no state between words.
module decimal_ascii_lcd_formatter_core
    import dalf_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word
);

    localparam int IW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    logic  [N_STAGES:0] st_valid;
    logic  [N_STAGES:0] st_stall;
    t_conv [N_STAGES:0] st_data;

    logic                   scan_valid;
    logic                   scan_stall;
    logic [CMD_W-1:0]       scan_cmd;
    logic [DIGITS-1:0][3:0] scan_digits;
    logic [IW-1:0]          scan_top;

    // Entry into the conversion chain: empty digits, value bits still to shift in.
    assign st_valid[0]     = i_valid;
    assign o_stall         = st_stall[0];
    assign st_data[0].cmd  = i_word.cursor_cmd;
    assign st_data[0].bits = i_word.value;
    assign st_data[0].bcd  = '0;

    // Binary to decimal conversion, eight bits per stage.
    for (genvar s = 0; s < N_STAGES; s++) begin : g_conv
        dalf_dabble_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (st_valid[s]),
            .o_stall (st_stall[s]),
            .i_data  (st_data[s]),
            .o_valid (st_valid[s+1]),
            .i_stall (st_stall[s+1]),
            .o_data  (st_data[s+1])
        );
    end

    dalf_scan #(
        .DIGITS (DIGITS)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (st_valid[N_STAGES]),
        .o_stall  (st_stall[N_STAGES]),
        .i_data   (st_data[N_STAGES]),
        .o_valid  (scan_valid),
        .i_stall  (scan_stall),
        .o_cmd    (scan_cmd),
        .o_digits (scan_digits),
        .o_top    (scan_top)
    );

    dalf_serializer #(
        .DIGITS (DIGITS)
    ) u_ser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (scan_valid),
        .o_stall  (scan_stall),
        .i_cmd    (scan_cmd),
        .i_digits (scan_digits),
        .i_top    (scan_top),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_word   (o_word)
    );

endmodule

/* rtl/dalf_checker.sv */
module dalf_checker
    import dalf_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_stall,
    input t_in_word  i_word,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_word o_word
);

    logic out_take;

    assign out_take = o_valid && !i_stall;

    // A command byte never ends a run.
    a_cmd_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word.is_command) |-> !o_word.last)
        else $error("command byte flagged as last");

    // Command bytes shown are always at or above the threshold.
    a_cmd_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word.is_command) |-> o_word.out_byte[BYTE_W-1])
        else $error("command byte below threshold");

    // Character bytes are decimal digits.
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_word.is_command) |->
        (o_word.out_byte >= ASCII_ZERO && o_word.out_byte <= ASCII_NINE))
        else $error("character byte is not a decimal digit");

    // A run continues without a gap once started.
    a_run_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && !o_word.last) |=> o_valid)
        else $error("gap inside an output run");

    // A stalled input word stays offered and unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_stall) |=> (i_valid && $stable(i_word)))
        else $error("stalled input word changed or was withdrawn");

endmodule

bind decimal_ascii_lcd_formatter_core dalf_checker u_dalf_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_word  (i_word),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_word  (o_word)
);
